### src/agc_pkg.sv
// ----------------------------------------------------------------------------
// Anagram group classifier package
// Shared constants, status codes and controller state type.
// ----------------------------------------------------------------------------
package agc_pkg;

    localparam int MAX_LEN_DEF    = 32;
    localparam int MAX_GROUPS_DEF = 64;
    localparam int CHAR_W         = 8;
    localparam int FIELD_W        = 6;
    localparam int STATUS_W       = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_TOO_LONG = 2'd1;
    localparam t_status ST_FULL     = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

endpackage

### src/agc_if.sv
// ----------------------------------------------------------------------------
// Anagram group classifier channels
// Character input channel and classification result channel.
// ----------------------------------------------------------------------------
interface agc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface agc_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] group_index;
    logic       new_group;
    logic [1:0] status;
    logic [5:0] word_length;

    modport source (output valid, output group_index, output new_group, output status,
                    output word_length, input ready);
    modport sink   (input valid, input group_index, input new_group, input status,
                    input word_length, output ready);
endinterface

### src/agc_sort_cell.sv
// ----------------------------------------------------------------------------
// Sort cell
// One slot of the insertion-sorted word buffer; shifts right or takes the
// new byte depending on its own and its left neighbor's compare.
// ----------------------------------------------------------------------------
module agc_sort_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_clr,
    input  logic [agc_pkg::CHAR_W-1:0]  i_char,
    input  logic [agc_pkg::CHAR_W-1:0]  i_left_data,
    input  logic                        i_left_vld,
    input  logic                        i_left_gt,
    output logic [agc_pkg::CHAR_W-1:0]  o_data,
    output logic                        o_vld,
    output logic                        o_gt
);
    import agc_pkg::*;

    logic [CHAR_W-1:0] r_data;
    logic              r_vld;
    logic              w_take;

    assign o_gt   = r_vld && (r_data > i_char);
    assign w_take = i_load && (o_gt || !r_vld) && i_left_vld;
    assign o_data = r_data;
    assign o_vld  = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= i_left_gt ? i_left_data : i_char;
        end
    end

endmodule

### src/agc_key_store.sv
// ----------------------------------------------------------------------------
// Key store
// One row per group holding key length and sorted bytes; registered read
// and a row-wide compare against the current key.
// ----------------------------------------------------------------------------
module agc_key_store #(
    parameter int MAX_LEN    = agc_pkg::MAX_LEN_DEF,
    parameter int MAX_GROUPS = agc_pkg::MAX_GROUPS_DEF,
    parameter int CW         = $clog2(MAX_LEN + 1),
    parameter int AW         = $clog2(MAX_GROUPS)
) (
    input  logic                                i_clk,
    input  logic                                i_rd_en,
    input  logic                                i_wr_en,
    input  logic [AW-1:0]                       i_addr,
    input  logic [MAX_LEN*agc_pkg::CHAR_W-1:0]  i_key,
    input  logic [MAX_LEN-1:0]                  i_mask,
    input  logic [CW-1:0]                       i_len,
    output logic                                o_match
);
    import agc_pkg::*;

    localparam int KW = MAX_LEN * CHAR_W;
    localparam int RW = KW + CW;

    logic [RW-1:0]      r_mem [MAX_GROUPS];
    logic [RW-1:0]      r_rd_data;
    logic [MAX_LEN-1:0] w_eq;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= {i_len, i_key};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_LEN; i++) begin
            w_eq[i] = !i_mask[i] ||
                      (r_rd_data[i*CHAR_W +: CHAR_W] == i_key[i*CHAR_W +: CHAR_W]);
        end
    end

    assign o_match = (r_rd_data[RW-1 -: CW] == i_len) && (&w_eq);

endmodule

### src/anagram_group_classifier.sv
// ----------------------------------------------------------------------------
// Anagram group classifier
// Sorts each word's bytes on arrival in a chain of cells, then walks the
// stored keys to find or open the word's group.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  i_in    | in  | char_code, last_char
//  o_out   | out | group_index, new_group, status, word_length
//
//  A character is accepted only in idle; the sort chain inserts it as it is
//  accepted. At word end the key table is walked one stored group at a time
//  (read, then compare); a walk that finds no key ends with a read step that
//  stores the key if the table has room. An overlong word goes straight to
//  done. Reset clears counts and cell valid bits; the key memory is never
//  cleared. A stalled result holds in o_out while characters of the next
//  word are accepted; the following result waits in done until o_out frees.
// ----------------------------------------------------------------------------
module anagram_group_classifier #(
    parameter int MAX_LEN    = agc_pkg::MAX_LEN_DEF,
    parameter int MAX_GROUPS = agc_pkg::MAX_GROUPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    agc_in_if.sink    i_in,
    agc_out_if.source o_out
);
    import agc_pkg::*;

    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int GCW = $clog2(MAX_GROUPS + 1);
    localparam int AW  = $clog2(MAX_GROUPS);

    t_state r_state, n_state;

    logic [CW-1:0]          r_count;
    logic                   r_too_long;
    logic [GCW-1:0]         r_gcnt;
    logic [GCW-1:0]         r_g;
    logic [GCW-1:0]         r_idx;
    logic                   r_new;
    t_status                r_stat;
    logic                   r_ovld;
    logic [FIELD_W-1:0]     r_oidx;
    logic                   r_onew;
    t_status                r_ostat;
    logic [FIELD_W-1:0]     r_olen;

    logic                   w_acc;
    logic                   w_full_word;
    logic                   w_load;
    logic                   w_rd;
    logic                   w_wr;
    logic                   w_out_load;
    logic                   w_match;
    logic                   w_end;

    logic [CHAR_W-1:0]         w_data [MAX_LEN];
    logic [MAX_LEN-1:0]        w_vld;
    logic [MAX_LEN-1:0]        w_gt;
    logic [MAX_LEN*CHAR_W-1:0] w_key;
    logic [31:0]               w_len32;
    logic [31:0]               w_idx32;

    assign w_acc       = i_in.valid && i_in.ready;
    assign w_full_word = (r_count == CW'(MAX_LEN));
    assign w_load      = w_acc && !w_full_word;
    assign w_end       = (r_g == r_gcnt);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
            logic [CHAR_W-1:0] w_ld;
            logic              w_lv;
            logic              w_lg;
            if (gi == 0) begin : g_first
                assign w_ld = '0;
                assign w_lv = 1'b1;
                assign w_lg = 1'b0;
            end else begin : g_rest
                assign w_ld = w_data[gi-1];
                assign w_lv = w_vld[gi-1];
                assign w_lg = w_gt[gi-1];
            end
            agc_sort_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_load      (w_load),
                .i_clr       (w_out_load),
                .i_char      (i_in.char_code),
                .i_left_data (w_ld),
                .i_left_vld  (w_lv),
                .i_left_gt   (w_lg),
                .o_data      (w_data[gi]),
                .o_vld       (w_vld[gi]),
                .o_gt        (w_gt[gi])
            );
            assign w_key[gi*CHAR_W +: CHAR_W] = w_data[gi];
        end
    endgenerate

    agc_key_store #(
        .MAX_LEN    (MAX_LEN),
        .MAX_GROUPS (MAX_GROUPS),
        .CW         (CW),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rd_en (w_rd),
        .i_wr_en (w_wr),
        .i_addr  (r_g[AW-1:0]),
        .i_key   (w_key),
        .i_mask  (w_vld),
        .i_len   (r_count),
        .o_match (w_match)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && i_in.last_char) begin
                    n_state = (r_too_long || w_full_word) ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                n_state = w_end ? S_DONE : S_CMP;
            end
            S_CMP: begin
                n_state = w_match ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (!r_ovld || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        w_rd       = 1'b0;
        w_wr       = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_READ: begin
                w_rd = !w_end;
                w_wr = w_end && (r_gcnt != GCW'(MAX_GROUPS));
            end
            S_CMP:  ;
            S_DONE: w_out_load = !r_ovld || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_out_load) begin
            r_count    <= '0;
            r_too_long <= 1'b0;
        end else if (w_acc) begin
            if (w_full_word) begin
                r_too_long <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcnt <= '0;
        end else if (w_wr) begin
            r_gcnt <= r_gcnt + GCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        priority case (r_state)
            S_IDLE: begin
                r_g    <= '0;
                r_idx  <= '0;
                r_new  <= 1'b0;
                r_stat <= (r_too_long || w_full_word) ? ST_TOO_LONG : ST_OK;
            end
            S_READ: begin
                if (w_end) begin
                    if (w_wr) begin
                        r_idx <= r_gcnt;
                        r_new <= 1'b1;
                    end else begin
                        r_stat <= ST_FULL;
                    end
                end
            end
            S_CMP: begin
                if (w_match) begin
                    r_idx <= r_g;
                end else begin
                    r_g <= r_g + GCW'(1);
                end
            end
            default: ;
        endcase
    end

    assign w_len32 = 32'(r_count);
    assign w_idx32 = 32'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_load) begin
            r_ovld <= 1'b1;
        end else if (o_out.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_oidx  <= w_idx32[FIELD_W-1:0];
            r_onew  <= r_new;
            r_ostat <= r_stat;
            r_olen  <= w_len32[FIELD_W-1:0];
        end
    end

    assign o_out.valid       = r_ovld;
    assign o_out.group_index = r_oidx;
    assign o_out.new_group   = r_onew;
    assign o_out.status      = r_ostat;
    assign o_out.word_length = r_olen;

    a_gcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gcnt <= GCW'(MAX_GROUPS))
        else $error("group count above table size");

    a_new_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.new_group |-> o_out.status == ST_OK)
        else $error("new group with error status");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");

    a_wr_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> r_gcnt == $past(r_gcnt) + GCW'(1))
        else $error("group count did not advance on store");

endmodule

### sim/anagram_group_classifier_tb.sv
// ----------------------------------------------------------------------------
// Anagram group classifier testbench
// Drives words a character at a time through the input channel. A local
// model sorts each word and keeps its own key table, so every result on the
// output channel can be checked. Directed cases cover lengths and table
// fill, then random words follow under varying stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module anagram_group_classifier_tb;
    import agc_pkg::*;

    localparam int MAXL  = MAX_LEN_DEF;
    localparam int MAXG  = MAX_GROUPS_DEF;
    localparam int LIMIT = 20000;

    typedef struct packed {
        logic [5:0] group_index;
        logic       new_group;
        t_status    status;
        logic [5:0] word_length;
    } t_result;

    typedef struct {
        logic [7:0] code;
        logic       last;
        logic       checked;
        t_result    res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    agc_in_if  in_ch();
    agc_out_if out_ch();

    anagram_group_classifier DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    logic [7:0] sorted_word[MAXL];
    int         word_chars;
    logic       word_overflow;
    logic [7:0] keys[MAXG][MAXL];
    int         key_len[MAXG];
    int         groups_open;

    t_result    pending_results[$];
    t_result    fixed_results[$];
    logic       fixed_flags[$];
    int         errors;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         recv_hold;
    bit         done;
    int         quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic t_result classify_char(input logic [7:0] c, input logic last);
        t_result r;
        int      pos;
        int      g;
        int      hit;
        r = '0;
        if (word_chars >= MAXL) begin
            word_overflow = 1'b1;
        end else begin
            pos = word_chars;
            while (pos > 0 && sorted_word[pos-1] > c) begin
                sorted_word[pos] = sorted_word[pos-1];
                pos--;
            end
            sorted_word[pos] = c;
            word_chars++;
        end
        if (!last) return r;
        if (word_overflow) begin
            r.status = ST_TOO_LONG;
        end else begin
            hit = -1;
            for (g = 0; g < groups_open && hit < 0; g++) begin
                if (key_len[g] == word_chars) begin
                    hit = g;
                    for (int k = 0; k < word_chars; k++)
                        if (keys[g][k] != sorted_word[k]) hit = -1;
                end
            end
            if (hit >= 0) begin
                r.group_index = hit[5:0];
            end else if (groups_open >= MAXG) begin
                r.status = ST_FULL;
            end else begin
                for (int k = 0; k < word_chars; k++) keys[groups_open][k] = sorted_word[k];
                key_len[groups_open] = word_chars;
                r.group_index = groups_open[5:0];
                r.new_group   = 1'b1;
                groups_open++;
            end
        end
        r.word_length = word_chars[5:0];
        word_chars    = 0;
        word_overflow = 1'b0;
        return r;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last, input logic checked,
                             input t_result want);
        t_result r;
        while (($urandom_range(99) < send_idle_pct)) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_code <= c;
        in_ch.last_char <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        r = classify_char(c, last);
        if (last) begin
            pending_results = {pending_results, r};
            fixed_results   = {fixed_results, want};
            fixed_flags     = {fixed_flags, checked};
        end
    endtask

    task automatic send_word(input int len, input int alpha);
        for (int i = 0; i < len; i++)
            send_char(8'($urandom_range(alpha - 1)), i == len - 1, 1'b0, '0);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result fixed;
        logic    use_fixed;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= LIMIT) begin
                $display("anagram_group_classifier_tb: errors");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.group_index, out_ch.new_group, out_ch.status,
                        out_ch.word_length};
                if (pending_results.size() == 0) begin
                    report("unexpected word", 1, 0);
                end else begin
                    want      = pending_results.pop_front();
                    fixed     = fixed_results.pop_front();
                    use_fixed = fixed_flags.pop_front();
                    if (use_fixed && fixed != want) report("table row", fixed, want);
                    if (got.group_index != want.group_index)
                        report("group_index", got.group_index, want.group_index);
                    if (got.new_group != want.new_group)
                        report("new_group", got.new_group, want.new_group);
                    if (got.status != want.status)
                        report("status", got.status, want.status);
                    if (got.word_length != want.word_length)
                        report("word_length", got.word_length, want.word_length);
                end
            end
        end
    end

    t_row rows[$];

    task automatic add_row(input logic [7:0] c, input logic last, input logic checked,
                           input t_result res);
        t_row r;
        r = '{c, last, checked, res};
        rows = {rows, r};
    endtask

    initial begin : hold_off
        recv_hold = 1'b0;
        wait (send_idle_pct == 1000);
        recv_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        recv_hold = 1'b0;
    end

    initial begin
        t_result ok;
        ok            = '0;
        errors        = 0;
        quiet_cycles  = 0;
        word_chars    = 0;
        word_overflow = 1'b0;
        groups_open   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.char_code <= '0;
        in_ch.last_char <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single chars at both extremes, then an anagram of a two-char key
        add_row(8'h00, 1'b1, 1'b1, '{6'd0, 1'b1, ST_OK, 6'd1});
        add_row(8'hFF, 1'b1, 1'b1, '{6'd1, 1'b1, ST_OK, 6'd1});
        add_row(8'h00, 1'b1, 1'b1, '{6'd0, 1'b0, ST_OK, 6'd1});
        add_row(8'hFF, 1'b0, 1'b0, ok);
        add_row(8'h00, 1'b1, 1'b1, '{6'd2, 1'b1, ST_OK, 6'd2});
        add_row(8'h00, 1'b0, 1'b0, ok);
        add_row(8'hFF, 1'b1, 1'b1, '{6'd2, 1'b0, ST_OK, 6'd2});
        add_row(8'hAA, 1'b0, 1'b0, ok);
        add_row(8'h55, 1'b1, 1'b1, '{6'd3, 1'b1, ST_OK, 6'd2});
        foreach (rows[i]) send_char(rows[i].code, rows[i].last, rows[i].checked, rows[i].res);

        // exactly full length, then one past it
        for (int i = 0; i < MAXL; i++) send_char(8'(i), i == MAXL - 1, 1'b0, ok);
        for (int i = 0; i <= MAXL; i++)
            send_char(8'(i * 7), i == MAXL, 1'b1, '{6'd0, 1'b0, ST_TOO_LONG, 6'(MAXL)});
        drain();

        // fill the table, then a fresh key and a known key
        while (groups_open < MAXG) send_char(8'(groups_open), 1'b1, 1'b0, ok);
        send_char(8'h12, 1'b0, 1'b0, ok);
        send_char(8'h34, 1'b0, 1'b0, ok);
        send_char(8'h56, 1'b1, 1'b1, '{6'd0, 1'b0, ST_FULL, 6'd3});
        send_char(8'hFF, 1'b1, 1'b1, '{6'd1, 1'b0, ST_OK, 6'd1});
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 32 : phase == 1 ? 83 : 0;
            recv_idle_pct = phase == 0 ? 83 : phase == 1 ? 32 : 0;
            if (phase == 2) begin
                in_ch.valid <= 1'b0;
                send_idle_pct = 1000;
                @(posedge i_clk);
                send_idle_pct = 0;
            end
            for (int n = 0; n < 30; n++) begin
                case ($urandom_range(9))
                    0:       send_word($urandom_range(MAXL + 4, MAXL - 1), 256);
                    1, 2:    send_word($urandom_range(MAXL, 1), 256);
                    default: send_word($urandom_range(3, 1), 4);
                endcase
            end
        end
        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("anagram_group_classifier_tb: clean");
        end else begin
            $display("anagram_group_classifier_tb: errors");
        end
        $finish;
    end

endmodule
